// File: rtl/crpu_pkg.sv
// crpu_pkg: types, constants and helper functions for the complex rect/polar unit.
// Used by complex_rect_polar_unit_top; depends on nothing else.
package crpu_pkg;

  // defaults for the top-level parameters
  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // internal datapath widths
  localparam int DW    = 35;  // cordic x and y
  localparam int ZW    = 35;  // angle accumulator, q2.30
  localparam int RW    = 35;  // remainder of the angle reduction
  localparam int SAT_W = 40;  // values entering the output clamp

  localparam logic [32:0]          TWO_PI_Q30   = 33'd6746518852;
  localparam logic signed [ZW-1:0] PI_Q30       = 35'sd3373259426;
  localparam logic signed [ZW-1:0] NEG_PI_Q30   = -35'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_S     = 35'sd6746518852;
  localparam logic signed [ZW-1:0] HALF_PI_Q30  = 35'sd1686629713;
  localparam logic signed [ZW-1:0] NEG_HALF_PI  = -35'sd1686629713;
  // floor(2^64 / TWO_PI_Q30) less a small margin, so the quotient estimate never runs high
  localparam logic [31:0]          RECIP_TWO_PI = 32'd2734261101;
  localparam logic signed [30:0]   GAIN_Q30     = 31'sd652032874;

  localparam logic signed [SAT_W-1:0] SAT_MAX = 40'sh007FFFFFFF;
  localparam logic signed [SAT_W-1:0] SAT_MIN = 40'shFF80000000;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_SUB      = 2'd1,
    CMD_TO_POLAR = 2'd2,
    CMD_TO_RECT  = 2'd3
  } crpu_cmd_e;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_VECTOR,
    MODE_ROTATE
  } crpu_mode_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } crpu_request_t;

  typedef struct packed {
    logic signed [31:0] result_re;
    logic signed [31:0] result_im;
    logic               overflow;
  } crpu_result_t;

  typedef struct packed {
    crpu_mode_e          mode;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } crpu_cordic_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               ovf;
  } crpu_sat_t;

  // arctangent of 2^-idx in q2.30
  function automatic logic [29:0] crpu_atan(input logic [4:0] idx);
    logic [29:0] a;
    case (idx)
      5'd0:  a = 30'd843314856;
      5'd1:  a = 30'd497837829;
      5'd2:  a = 30'd263043836;
      5'd3:  a = 30'd133525158;
      5'd4:  a = 30'd67021686;
      5'd5:  a = 30'd33543515;
      5'd6:  a = 30'd16775850;
      5'd7:  a = 30'd8388437;
      5'd8:  a = 30'd4194282;
      5'd9:  a = 30'd2097149;
      5'd10: a = 30'd1048575;
      5'd11: a = 30'd524287;
      5'd12: a = 30'd262143;
      5'd13: a = 30'd131071;
      5'd14: a = 30'd65535;
      5'd15: a = 30'd32767;
      5'd16: a = 30'd16383;
      5'd17: a = 30'd8191;
      5'd18: a = 30'd4095;
      5'd19: a = 30'd2047;
      5'd20: a = 30'd1023;
      5'd21: a = 30'd511;
      5'd22: a = 30'd255;
      5'd23: a = 30'd127;
      5'd24: a = 30'd63;
      5'd25: a = 30'd31;
      5'd26: a = 30'd15;
      5'd27: a = 30'd8;
      5'd28: a = 30'd4;
      5'd29: a = 30'd2;
      5'd30: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // clamp to the signed 32-bit range
  function automatic crpu_sat_t crpu_sat(input logic signed [SAT_W-1:0] v);
    crpu_sat_t s;
    if (v > SAT_MAX) begin
      s.value = 32'sh7FFFFFFF;
      s.ovf   = 1'b1;
    end else if (v < SAT_MIN) begin
      s.value = 32'sh80000000;
      s.ovf   = 1'b1;
    end else begin
      s.value = v[31:0];
      s.ovf   = 1'b0;
    end
    return s;
  endfunction

endpackage

// File: rtl/complex_rect_polar_unit_top.sv
// complex_rect_polar_unit_top: pipelined complex add/subtract and cordic rect/polar conversion.
// Depends on crpu_pkg for the request/result types, constants and the arctangent table.
//
// Usage: drive a request (command, a_re, a_im, b_re, b_im in signed fixed point with
// FRACTION_BITS fraction bits) and raise start; the request is taken at the clock edge
// where start is high and busy is low. busy stays low, so one request can enter every cycle.
// Each request yields one result. done is high for exactly one cycle while result holds
// result_re, result_im and overflow; the result must be taken in that cycle.
// Pipeline: a request passes the same stages after it is taken, whatever its
// command: six stages reduce the rotation angle modulo 2*pi (magnitude, reciprocal multiply,
// quotient multiply, subtract, correction and sign, wrap to +/-pi), one stage folds the
// operands into the cordic range, one stage per cordic iteration, then two stages apply
// the cordic gain, round and clamp. Add and subtract ride the same pipeline untouched.
// Throughput: one request per cycle, in order.
// Reset (rst, synchronous) clears all valid bits; requests in flight are dropped and no
// done strobe follows. Results leave with no back-pressure.
module complex_rect_polar_unit_top
  import crpu_pkg::*;
#(
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  crpu_request_t request,
  output logic          done,
  output crpu_result_t  result
);

  localparam int SHIFT_Q = 30 - FRACTION_BITS;  // q30 over input fraction
  localparam int QW      = 30 - FRACTION_BITS;  // quotient width
  localparam int AW      = 32 + SHIFT_Q;        // |angle| in q30
  localparam int MW      = AW + 1;
  localparam int LOW_W   = 17;                  // low split of the gain multiply
  localparam int PW      = 49;                  // partial product width
  localparam int GW      = 66;                  // gain sum width
  localparam logic signed [ZW-1:0] ANG_ROUND  = ZW'(1) << (29 - FRACTION_BITS);
  localparam logic [GW-1:0]        GAIN_ROUND = GW'(1) << 29;

  assign busy = 1'b0;

  // angle reduction pipeline
  logic          v1, v2, v3, v4, v5, v6;
  crpu_request_t req1, req2, req3, req4, req5, req6;
  logic [31:0]   abs1, abs2, abs3;
  logic          neg1, neg2, neg3, neg4;
  logic [63:0]   prod2;
  logic [MW-1:0] mq3;
  logic [RW-1:0] r4;
  logic signed [ZW-1:0] z5, z6;

  logic [31:0]          abs_in;
  logic [AW-1:0]        big_a;
  logic [MW-1:0]        diff4;
  logic [RW-1:0]        r_corr;
  logic signed [ZW-1:0] z5_next, z6_next;

  assign abs_in = request.a_im[31] ? (~request.a_im + 32'd1) : request.a_im;
  assign big_a  = {abs3, {SHIFT_Q{1'b0}}};
  assign diff4  = {1'b0, big_a} - mq3;
  assign r_corr = (r4 >= RW'(TWO_PI_Q30)) ? (r4 - RW'(TWO_PI_Q30)) : r4;
  assign z5_next = neg4 ? -$signed(r_corr) : $signed(r_corr);

  always_comb begin
    if (z5 > PI_Q30) begin
      z6_next = z5 - TWO_PI_S;
    end else if (z5 < NEG_PI_Q30) begin
      z6_next = z5 + TWO_PI_S;
    end else begin
      z6_next = z5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    req1  <= request;
    abs1  <= abs_in;
    neg1  <= request.a_im[31];
    req2  <= req1;
    abs2  <= abs1;
    neg2  <= neg1;
    prod2 <= 64'(abs1) * 64'(RECIP_TWO_PI);
    req3  <= req2;
    abs3  <= abs2;
    neg3  <= neg2;
    mq3   <= MW'(prod2[63 -: QW]) * MW'(TWO_PI_Q30);
    req4  <= req3;
    neg4  <= neg3;
    r4    <= diff4[RW-1:0];
    req5  <= req4;
    z5    <= z5_next;
    req6  <= req5;
    z6    <= z6_next;
  end

  // operand fold into the cordic range
  logic signed [DW-1:0] are, aim, bre, bim;
  crpu_cordic_t         init;

  assign are = {{(DW-32){req6.a_re[31]}}, req6.a_re};
  assign aim = {{(DW-32){req6.a_im[31]}}, req6.a_im};
  assign bre = {{(DW-32){req6.b_re[31]}}, req6.b_re};
  assign bim = {{(DW-32){req6.b_im[31]}}, req6.b_im};

  always_comb begin
    init.mode = MODE_PASS;
    init.x    = '0;
    init.y    = '0;
    init.z    = '0;
    case (req6.command)
      CMD_ADD: begin
        init.x = are + bre;
        init.y = aim + bim;
      end
      CMD_SUB: begin
        init.x = are - bre;
        init.y = aim - bim;
      end
      CMD_TO_POLAR: begin
        // zero vector passes through as magnitude 0, angle 0
        if ((are != '0) || (aim != '0)) begin
          init.mode = MODE_VECTOR;
          if (!are[DW-1]) begin
            init.x = are;
            init.y = aim;
          end else if (!aim[DW-1]) begin
            init.x = aim;
            init.y = -are;
            init.z = HALF_PI_Q30;
          end else begin
            init.x = -aim;
            init.y = are;
            init.z = NEG_HALF_PI;
          end
        end
      end
      CMD_TO_RECT: begin
        init.mode = MODE_ROTATE;
        if (z6 > HALF_PI_Q30) begin
          init.y = are;
          init.z = z6 - HALF_PI_Q30;
        end else if (z6 < NEG_HALF_PI) begin
          init.y = -are;
          init.z = z6 + HALF_PI_Q30;
        end else begin
          init.x = are;
          init.z = z6;
        end
      end
      default: begin
        init.mode = MODE_PASS;
      end
    endcase
  end

  // cordic iterations, one register stage each
  crpu_cordic_t cst [CORDIC_STEPS+1];
  logic         cv  [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    cst[0] <= init;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [DW-1:0] dx, dy;
    logic signed [ZW-1:0] da;
    logic                 cw;
    crpu_cordic_t         nxt;

    assign dx = cst[k].y >>> k;
    assign dy = cst[k].x >>> k;
    assign da = $signed({{(ZW-30){1'b0}}, crpu_atan(5'(k))});
    // vectoring drives y to zero, rotation drives z to zero
    assign cw = (cst[k].mode == MODE_VECTOR) ?
                (!cst[k].y[DW-1] && (cst[k].y != '0)) : cst[k].z[ZW-1];

    always_comb begin
      nxt = cst[k];
      if (cst[k].mode != MODE_PASS) begin
        if (cw) begin
          nxt.x = cst[k].x + dx;
          nxt.y = cst[k].y - dy;
          nxt.z = cst[k].z + da;
        end else begin
          nxt.x = cst[k].x - dx;
          nxt.y = cst[k].y + dy;
          nxt.z = cst[k].z - da;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else begin
        cv[k+1] <= cv[k];
      end
    end

    always_ff @(posedge clk) begin
      cst[k+1] <= nxt;
    end
  end

  // gain multiply, split in two partial products per component
  crpu_cordic_t         gst;
  logic                 gv;
  logic signed [PW-1:0] ph_x, pl_x, ph_y, pl_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      gv <= 1'b0;
    end else begin
      gv <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    gst  <= cst[CORDIC_STEPS];
    ph_x <= PW'($signed(cst[CORDIC_STEPS].x[DW-1:LOW_W])) * PW'(GAIN_Q30);
    pl_x <= PW'($signed({1'b0, cst[CORDIC_STEPS].x[LOW_W-1:0]})) * PW'(GAIN_Q30);
    ph_y <= PW'($signed(cst[CORDIC_STEPS].y[DW-1:LOW_W])) * PW'(GAIN_Q30);
    pl_y <= PW'($signed({1'b0, cst[CORDIC_STEPS].y[LOW_W-1:0]})) * PW'(GAIN_Q30);
  end

  // recombine, round, select and clamp
  logic [GW-1:0]        gx, gy;
  logic signed [ZW-1:0] za, ang;
  logic signed [SAT_W-1:0] re_w, im_w;
  crpu_sat_t            re_s, im_s;

  assign gx = ({{(GW-PW){ph_x[PW-1]}}, ph_x} << LOW_W)
            + {{(GW-PW){pl_x[PW-1]}}, pl_x} + GAIN_ROUND;
  assign gy = ({{(GW-PW){ph_y[PW-1]}}, ph_y} << LOW_W)
            + {{(GW-PW){pl_y[PW-1]}}, pl_y} + GAIN_ROUND;
  assign za  = gst.z + ANG_ROUND;
  assign ang = za >>> SHIFT_Q;

  always_comb begin
    case (gst.mode)
      MODE_VECTOR: begin
        re_w = {{(SAT_W-(GW-30)){gx[GW-1]}}, gx[GW-1:30]};
        im_w = {{(SAT_W-ZW){ang[ZW-1]}}, ang};
      end
      MODE_ROTATE: begin
        re_w = {{(SAT_W-(GW-30)){gx[GW-1]}}, gx[GW-1:30]};
        im_w = {{(SAT_W-(GW-30)){gy[GW-1]}}, gy[GW-1:30]};
      end
      default: begin
        re_w = {{(SAT_W-DW){gst.x[DW-1]}}, gst.x};
        im_w = {{(SAT_W-DW){gst.y[DW-1]}}, gst.y};
      end
    endcase
    re_s = crpu_sat(re_w);
    im_s = crpu_sat(im_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= gv;
    end
  end

  always_ff @(posedge clk) begin
    result.result_re <= re_s.value;
    result.result_im <= im_s.value;
    result.overflow  <= re_s.ovf | im_s.ovf;
  end

endmodule

// File: test/tb_complex_rect_polar_unit_top.sv
// tb_complex_rect_polar_unit_top: self-checking testbench for the complex rect/polar unit.
// Predicts every result with its own arithmetic (cordic for the conversions) and compares field by field.
// Depends on crpu_pkg and complex_rect_polar_unit_top.
module tb_complex_rect_polar_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crpu_pkg::*;

  localparam int     STEPS       = CORDIC_STEPS_DEF;
  localparam int     FRAC        = FRACTION_BITS_DEF;
  localparam int     LATENCY     = STEPS + 9;
  localparam int     N_RANDOM    = 1600;
  localparam int     MAX_GAP     = 12;
  localparam longint TIMEOUT_NS  = 1000000;

  localparam longint ANG_PI      = 64'sd3373259426;
  localparam longint ANG_HALF_PI = 64'sd1686629713;
  localparam longint ANG_TWO_PI  = 64'sd6746518852;
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint ROUND_Q30   = 64'sd536870912;

  // atan(2^-i) in q2.30
  longint atan_tbl [0:30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535,
    32767, 16383, 8191, 4095, 2047,
    1023, 511, 255, 127, 63,
    31, 15, 8, 4, 2, 1
  };

  logic          clk   = 1'b0;
  logic          rst   = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  crpu_request_t request = '0;
  logic          done;
  crpu_result_t  result;

  crpu_request_t request_q[$];
  int            gap_q[$];
  crpu_result_t  predicted_q[$];
  crpu_result_t  want;

  logic took      = 1'b0;
  logic burst     = 1'b0;
  int   idle_left = 0;
  int   n_items   = 0;
  int   n_taken   = 0;
  int   n_results = 0;
  int   n_saturated = 0;
  int   n_errors  = 0;
  int   n_by_cmd [4] = '{0, 0, 0, 0};

  complex_rect_polar_unit_top u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #1 clk = ~clk;

  function automatic longint gain_round(input longint v);
    return (v * CORDIC_GAIN + ROUND_Q30) >>> 30;
  endfunction

  function automatic void polar_of(input longint xi, input longint yi,
                                   output longint mag, output longint ang);
    longint x, y, z, t, dx, dy;
    int i;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    // left half plane: rotate by a quarter turn first
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = ANG_HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -ANG_HALF_PI;
      end
    end
    for (i = 0; i < STEPS && i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_tbl[i];
      end else begin
        x -= dx; y += dy; z -= atan_tbl[i];
      end
    end
    mag = gain_round(x);
    ang = (z + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  function automatic void rect_of(input longint r, input longint a,
                                  output longint out_re, output longint out_im);
    longint x, y, z, t, dx, dy;
    int i;
    x = r;
    y = 0;
    // truncating remainder, then wrap into +/-pi
    z = (a * (longint'(1) << (30 - FRAC))) % ANG_TWO_PI;
    if (z > ANG_PI) z -= ANG_TWO_PI;
    if (z < -ANG_PI) z += ANG_TWO_PI;
    if (z > ANG_HALF_PI) begin
      t = x; x = -y; y = t; z -= ANG_HALF_PI;
    end else if (z < -ANG_HALF_PI) begin
      t = x; x = y; y = -t; z += ANG_HALF_PI;
    end
    for (i = 0; i < STEPS && i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tbl[i];
      end else begin
        x += dx; y -= dy; z += atan_tbl[i];
      end
    end
    out_re = gain_round(x);
    out_im = gain_round(y);
  endfunction

  function automatic logic [31:0] clamp32(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic crpu_result_t predict_result(input crpu_request_t rq);
    crpu_result_t res;
    longint ar, ai, br, bi, re, im;
    logic sat;
    ar  = longint'(rq.a_re);
    ai  = longint'(rq.a_im);
    br  = longint'(rq.b_re);
    bi  = longint'(rq.b_im);
    sat = 1'b0;
    case (rq.command)
      CMD_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      CMD_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      CMD_TO_POLAR: polar_of(ar, ai, re, im);
      default: rect_of(ar, ai, re, im);
    endcase
    res.result_re = clamp32(re, sat);
    res.result_im = clamp32(im, sat);
    res.overflow  = sat;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic add_item(input logic [1:0] cmd, input logic [31:0] ar, input logic [31:0] ai,
                          input logic [31:0] br, input logic [31:0] bi);
    crpu_request_t rq;
    rq.command = cmd;
    rq.a_re    = ar;
    rq.a_im    = ai;
    rq.b_re    = br;
    rq.b_im    = bi;
    request_q.push_back(rq);
    gap_q.push_back(burst ? 0 : $urandom_range(0, MAX_GAP));
    n_items++;
  endtask

  // full-range words, with extremes, zero/minus one and small values mixed in
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      3, 4, 5: return $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
      default: return $urandom();
    endcase
  endfunction

  // driver: holds a request until it is taken, then idles for its drawn gap
  always @(negedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else if (!start || took) begin
      if (idle_left != 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (request_q.size() != 0) begin
        request   <= request_q.pop_front();
        idle_left <= gap_q.pop_front();
        start     <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predicts on each taken request, checks each done strobe
  always @(posedge clk) begin
    took <= !rst && start && !busy;
    if (!rst && done) begin
      if (predicted_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = predicted_q.pop_front();
        if (result.result_re !== want.result_re)
          report_mismatch($sformatf("result %0d re got %0d want %0d", n_results,
                                    $signed(result.result_re), $signed(want.result_re)));
        if (result.result_im !== want.result_im)
          report_mismatch($sformatf("result %0d im got %0d want %0d", n_results,
                                    $signed(result.result_im), $signed(want.result_im)));
        if (result.overflow !== want.overflow)
          report_mismatch($sformatf("result %0d overflow got %b want %b", n_results,
                                    result.overflow, want.overflow));
        if (want.overflow) n_saturated++;
        n_results++;
      end
    end
    if (!rst && start && !busy) begin
      predicted_q.push_back(predict_result(request));
      n_by_cmd[request.command]++;
      n_taken++;
    end
  end

  initial begin
    int n;
    logic [1:0] op;
    logic [31:0] ang;

    // directed: saturation on both bounds, axes, zero vector, angle wrap, signed radius
    add_item(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h1);
    add_item(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    add_item(CMD_ADD, 32'h0, 32'h0, 32'h0, 32'h0);
    add_item(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h8000_0000);
    add_item(CMD_SUB, 12345, -6789, 32'h1000, 32'h20000);
    add_item(CMD_TO_POLAR, 0, 0, $urandom(), $urandom());
    add_item(CMD_TO_POLAR, -65536, 0, $urandom(), $urandom());
    add_item(CMD_TO_POLAR, 32'h8000_0000, 0, 0, 0);
    add_item(CMD_TO_POLAR, 0, 65536, 0, 0);
    add_item(CMD_TO_POLAR, 0, -65536, 0, 0);
    add_item(CMD_TO_POLAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    add_item(CMD_TO_POLAR, 32'h8000_0000, 32'h8000_0000, 0, 0);
    add_item(CMD_TO_POLAR, -1, -1, 0, 0);
    add_item(CMD_TO_POLAR, 65536, 65536, 0, 0);
    add_item(CMD_TO_RECT, 65536, 0, $urandom(), $urandom());
    add_item(CMD_TO_RECT, 65536, 205887, 0, 0);
    add_item(CMD_TO_RECT, 65536, -205887, 0, 0);
    add_item(CMD_TO_RECT, 65536, 32'h7FFF_FFFF, 0, 0);
    add_item(CMD_TO_RECT, 65536, 32'h8000_0000, 0, 0);
    add_item(CMD_TO_RECT, -65536, 51472, 0, 0);
    add_item(CMD_TO_RECT, 32'h7FFF_FFFF, 0, 0, 0);
    add_item(CMD_TO_RECT, 32'h8000_0000, 102944, 0, 0);
    add_item(CMD_TO_RECT, 32'h7FFF_FFFF, 51472, 0, 0);
    add_item(CMD_TO_RECT, 0, 12345, 0, 0);

    for (n = 0; n < N_RANDOM; n++) begin
      // blocks of back-to-back requests between stretches with gaps
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      op = 2'($urandom_range(0, 3));
      if (op == CMD_TO_RECT && $urandom_range(0, 2) != 0)
        ang = $urandom_range(0, 1647098) - 823549;  // within +/-4*pi
      else
        ang = rand_word();
      add_item(op, rand_word(), ang, rand_word(), rand_word());
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (n_taken == n_items);
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("covered %0d requests: %0d add, %0d subtract, %0d to-polar, %0d to-rect",
             n_taken, n_by_cmd[CMD_ADD], n_by_cmd[CMD_SUB], n_by_cmd[CMD_TO_POLAR],
             n_by_cmd[CMD_TO_RECT]);
    $display("%0d results checked, %0d saturated, %0d mismatches",
             n_results, n_saturated, n_errors);
    if (n_errors == 0) begin
      $display("complex_rect_polar_unit_top regression: pass");
    end else begin
      $display("complex_rect_polar_unit_top regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results still outstanding", predicted_q.size());
    $display("complex_rect_polar_unit_top regression: fail");
    $finish;
  end

endmodule
